// ===== hdl/sbb_pkg.sv =====
// Shared widths, register codes, defaults, types and the band edge function of the bar graph.
package sbb_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int MAG_W   = 16;
    localparam int BAND_W  = 5;
    localparam int ROW_W   = 3;
    localparam int INTEN_W = 7;
    localparam int GAIN_W  = 8;
    localparam int CAP_W   = 3;
    localparam int BIN_W   = 7;
    localparam int FRAC_W  = 8;
    localparam int LEVEL_W = CAP_W + FRAC_W;
    localparam int ROOT_W  = MAG_W;
    localparam int PROD_W  = ROOT_W + GAIN_W;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Defaults of the top-level parameters.
    localparam int NUM_BANDS_DEF = 22;
    localparam int MAX_BIN_DEF   = 100;
    localparam int NUM_ROWS_DEF  = 6;

    // Bands span this many octaves of bin count.
    localparam int OCTAVE_SPAN = 5;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CAP  = 1'b1;

    // Register reset values.
    localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST = 8'd36;
    localparam logic [CAP_W-1:0]  LEVEL_CAP_RST  = 3'd6;

    // Full brightness in percent.
    localparam logic [INTEN_W-1:0] PERCENT_FULL = 7'd100;

    // One bar update handed to the row sequencer.
    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
    } sbb_update_t;

    // Exclusive end bin of band x: floor(2^(span*x/(nb-1))), at least one past the
    // previous end, limited to mb. Evaluated at elaboration only.
    function automatic logic [BIN_W-1:0] band_end_f(input int x, input int nb, input int mb);
        logic [159:0] pw;
        logic [159:0] lim;
        int start;
        int e_end;
        bit fits;
        start = 0;
        e_end = 1;
        for (int b = 0; b <= x; b++) begin
            e_end = 1;
            fits = 1'b1;
            lim = 160'd1 << (OCTAVE_SPAN * b);
            for (int e = 1; e <= 32; e++) begin
                if (fits) begin
                    pw = 160'd1;
                    for (int n = 0; n < nb - 1; n++) begin
                        pw = pw * 160'(e);
                    end
                    if (pw <= lim) begin
                        e_end = e;
                    end else begin
                        fits = 1'b0;
                    end
                end
            end
            if (e_end <= start) begin
                e_end = start + 1;
            end
            if (e_end > mb) begin
                e_end = mb;
            end
            if (e_end > start) begin
                start = e_end;
            end
        end
        return BIN_W'(e_end);
    endfunction

endpackage

// ===== hdl/spectrum_band_bargraph_top.sv =====
// Top level of the log-spaced spectrum bar graph: band grouping, peak hold and level store.
//
//  Channel | Direction | Handshake           | Payload
//  s_      | in        | s_tvalid / s_tready | s_tdata: magnitude; s_tuser: frame_start
//  m_      | out       | m_tvalid / m_tready | m_tdata: band, row, intensity; m_tlast: last
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A bin that does not close a band leaves the controller idle. A bin that closes a band and
// changes its bar passes through 16 root steps, 8 multiply steps, a saturation step and one row
// per cycle into the output register before the next input transfer; an unchanged level skips
// the row phase. Output stalls lengthen the row phase; no input is taken until the last row is
// registered. Reset is synchronous and clears the previous-level store.
module spectrum_band_bargraph_top #(
    parameter int NUM_BANDS = sbb_pkg::NUM_BANDS_DEF,
    parameter int MAX_BIN   = sbb_pkg::MAX_BIN_DEF,
    parameter int NUM_ROWS  = sbb_pkg::NUM_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sbb_pkg::S_DATA_W-1:0]      s_tdata,   // [15:0] magnitude
    input  logic [0:0]                        s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbb_pkg::M_DATA_W-1:0]      m_tdata,   // [4:0] band, [7:5] row,
                                                         // [14:8] intensity, [15] zero
    output logic                              m_tlast,   // last row of a band update
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int BIDX_W = $clog2(NUM_BANDS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROOT  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_ROWS  = 3'd3;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [sbb_pkg::GAIN_W-1:0]       gain_reg;
    logic [sbb_pkg::CAP_W-1:0]        cap_reg;
    logic [sbb_pkg::MAG_W-1:0]        band_peak_reg;
    logic [sbb_pkg::BIN_W-1:0]        bin_counter_reg;
    logic [BIDX_W-1:0]                band_index_reg;
    logic [BIDX_W-1:0]                cur_band_reg;
    logic [sbb_pkg::LEVEL_W-1:0]      prev_level_reg [NUM_BANDS];
    logic [sbb_pkg::BIN_W-1:0]        band_end_tab [NUM_BANDS];

    logic                             in_xfer;
    logic [sbb_pkg::MAG_W-1:0]        magnitude;
    logic                             frame_start;
    logic [sbb_pkg::BIN_W-1:0]        end_cur;
    logic                             in_band;
    logic                             closes_band;
    logic [sbb_pkg::MAG_W-1:0]        peak_new;
    logic                             root_start;
    logic                             root_done;
    logic [sbb_pkg::ROOT_W-1:0]       root;
    logic                             scale_done;
    logic [sbb_pkg::LEVEL_W-1:0]      scale_level;
    logic                             level_changed;
    logic                             rows_start;
    logic                             rows_busy;
    sbb_pkg::sbb_update_t             rows_req;

    // Band edge table, fixed at elaboration.
    for (genvar g = 0; g < NUM_BANDS; g++) begin : g_edge
        assign band_end_tab[g] = sbb_pkg::band_end_f(g, NUM_BANDS, MAX_BIN);
    end

    // Input decode and band membership of the incoming bin.
    always_comb begin
        magnitude   = s_tdata[sbb_pkg::MAG_W-1:0];
        frame_start = s_tuser[0];
        in_xfer     = s_tvalid && s_tready;
        end_cur     = band_end_tab[band_index_reg];
        in_band     = (bin_counter_reg < end_cur);
        closes_band = in_band
                   && (({1'b0, bin_counter_reg} + 1'b1) == {1'b0, end_cur});
        peak_new    = (magnitude > band_peak_reg) ? magnitude : band_peak_reg;
        root_start  = in_xfer && !frame_start && closes_band;
        level_changed = (scale_level != prev_level_reg[cur_band_reg]);
        rows_start  = (state_reg == ST_SCALE) && scale_done && level_changed;
        rows_req.band  = sbb_pkg::BAND_W'(cur_band_reg);
        rows_req.level = scale_level;
    end

    // Sequencer of one band update.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (root_start) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (scale_done) begin
                    state_next = level_changed ? ST_ROWS : ST_IDLE;
                end
            end
            ST_ROWS: begin
                if (!rows_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Configuration registers; every write is taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= sbb_pkg::LEVEL_GAIN_RST;
            cap_reg  <= sbb_pkg::LEVEL_CAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sbb_pkg::REG_LEVEL_GAIN: gain_reg <= cfg_data[sbb_pkg::GAIN_W-1:0];
                sbb_pkg::REG_LEVEL_CAP:  cap_reg  <= cfg_data[sbb_pkg::CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Bin counting, band stepping and peak hold.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_peak_reg   <= '0;
            bin_counter_reg <= '0;
            band_index_reg  <= '0;
        end else if (in_xfer) begin
            if (frame_start) begin
                band_peak_reg   <= '0;
                bin_counter_reg <= '0;
                band_index_reg  <= '0;
            end else begin
                if (bin_counter_reg != '1) begin
                    bin_counter_reg <= bin_counter_reg + 1'b1;
                end
                if (closes_band) begin
                    band_peak_reg <= '0;
                    if (band_index_reg != BIDX_W'(NUM_BANDS - 1)) begin
                        band_index_reg <= band_index_reg + 1'b1;
                    end
                end else if (in_band) begin
                    band_peak_reg <= peak_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (root_start) begin
            cur_band_reg <= band_index_reg;
        end
    end

    // Previous level of every band, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                prev_level_reg[i] <= '0;
            end
        end else if (rows_start) begin
            prev_level_reg[cur_band_reg] <= scale_level;
        end
    end

    sbb_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (peak_new),
        .done     (root_done),
        .root     (root)
    );

    sbb_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((state_reg == ST_ROOT) && root_done),
        .root    (root),
        .gain    (gain_reg),
        .cap     (cap_reg),
        .done    (scale_done),
        .level   (scale_level)
    );

    sbb_rows #(
        .NUM_ROWS (NUM_ROWS)
    ) u_rows (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rows_start),
        .req      (rows_req),
        .busy     (rows_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // The band pointer never runs past the last band.
    a_band_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        band_index_reg <= BIDX_W'(NUM_BANDS - 1))
        else $error("band index beyond last band");

    // A finished level never exceeds the configured cap.
    a_level_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        scale_done |-> (scale_level <= {cap_reg, {sbb_pkg::FRAC_W{1'b0}}}))
        else $error("level above cap");

    // The row sequencer only runs while the controller waits for it.
    a_rows_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_busy |-> (state_reg == ST_ROWS))
        else $error("row sequencer busy outside row phase");

    // The peak of a closed band is cleared before the next band collects.
    a_peak_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        root_start |=> (band_peak_reg == '0))
        else $error("band peak not cleared after band close");
`endif

endmodule

// ===== hdl/sbb_isqrt.sv =====
// Bit-serial integer square root of a band peak with ROOT_W zero bits appended, one root bit per cycle.
module sbb_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sbb_pkg::MAG_W-1:0]   radicand,
    output logic                        done,
    output logic [sbb_pkg::ROOT_W-1:0]  root
);

    localparam int ITER  = sbb_pkg::ROOT_W;
    localparam int CNT_W = $clog2(ITER);
    localparam int REM_W = sbb_pkg::ROOT_W + 4;
    localparam int VAL_W = 2 * sbb_pkg::ROOT_W;

    logic [VAL_W-1:0]             val_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [sbb_pkg::ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [REM_W-1:0]             rem_shift;
    logic [REM_W-1:0]             trial;
    logic                         take;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[VAL_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: radicand shifter, partial remainder and root.
    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= {radicand, {sbb_pkg::ROOT_W{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[VAL_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[sbb_pkg::ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/sbb_scale.sv =====
// Serial gain multiplier on the root, followed by saturation to the bar cap in Q3.8.
module sbb_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [sbb_pkg::ROOT_W-1:0]   root,
    input  logic [sbb_pkg::GAIN_W-1:0]   gain,
    input  logic [sbb_pkg::CAP_W-1:0]    cap,
    output logic                         done,
    output logic [sbb_pkg::LEVEL_W-1:0]  level
);

    localparam int CNT_W = $clog2(sbb_pkg::GAIN_W);
    localparam int HI_W  = sbb_pkg::PROD_W - sbb_pkg::FRAC_W;

    logic [sbb_pkg::PROD_W-1:0]   acc_reg;
    logic [sbb_pkg::PROD_W-1:0]   acc_next;
    logic [sbb_pkg::GAIN_W-1:0]   gain_sh_reg;
    logic [sbb_pkg::ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         sat_reg;
    logic                         done_reg;
    logic [sbb_pkg::LEVEL_W-1:0]  level_reg;
    logic [sbb_pkg::LEVEL_W-1:0]  cap_level;
    logic [HI_W-1:0]              prod_hi;

    // Shift-and-add, gain bits taken most significant first.
    always_comb begin
        acc_next = {acc_reg[sbb_pkg::PROD_W-2:0], 1'b0}
                 + (gain_sh_reg[sbb_pkg::GAIN_W-1]
                    ? sbb_pkg::PROD_W'(root_reg) : '0);
        prod_hi   = acc_reg[sbb_pkg::PROD_W-1:sbb_pkg::FRAC_W];
        cap_level = {cap, {sbb_pkg::FRAC_W{1'b0}}};
    end

    // Sequencing: multiply steps, then a saturation step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(sbb_pkg::GAIN_W - 1)) begin
                    busy_reg <= 1'b0;
                    sat_reg  <= 1'b1;
                end
            end else if (sat_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg     <= '0;
            gain_sh_reg <= gain;
            root_reg    <= root;
        end else if (busy_reg) begin
            acc_reg     <= acc_next;
            gain_sh_reg <= {gain_sh_reg[sbb_pkg::GAIN_W-2:0], 1'b0};
        end
        if (sat_reg) begin
            if (prod_hi > HI_W'(cap_level)) begin
                level_reg <= cap_level;
            end else begin
                level_reg <= prod_hi[sbb_pkg::LEVEL_W-1:0];
            end
        end
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

// ===== hdl/sbb_rows.sv =====
// Row sequencer: one intensity transfer per LED row through a registered output stage.
module sbb_rows #(
    parameter int NUM_ROWS = sbb_pkg::NUM_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  sbb_pkg::sbb_update_t           req,
    output logic                           busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sbb_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int PCT_PROD_W = sbb_pkg::FRAC_W + sbb_pkg::INTEN_W;
    localparam int PAD_W = sbb_pkg::M_DATA_W - sbb_pkg::BAND_W - sbb_pkg::ROW_W
                         - sbb_pkg::INTEN_W;

    logic                          busy_reg;
    logic [RW-1:0]                 row_reg;
    logic [sbb_pkg::BAND_W-1:0]    band_reg;
    logic [sbb_pkg::CAP_W-1:0]     whole_reg;
    logic [sbb_pkg::FRAC_W-1:0]    frac_reg;
    logic                          tvalid_reg;
    logic [sbb_pkg::M_DATA_W-1:0]  tdata_reg;
    logic                          tlast_reg;
    logic                          load_out;
    logic                          row_last;
    logic [sbb_pkg::ROW_W-1:0]     row_ext;
    logic [PCT_PROD_W-1:0]         pct_prod;
    logic [sbb_pkg::INTEN_W-1:0]   intensity;

    // Intensity of the current row against the integer and fractional level.
    always_comb begin
        row_ext  = sbb_pkg::ROW_W'(row_reg);
        row_last = (row_reg == RW'(NUM_ROWS - 1));
        pct_prod = PCT_PROD_W'(frac_reg) * PCT_PROD_W'(sbb_pkg::PERCENT_FULL);
        if (row_ext < whole_reg) begin
            intensity = sbb_pkg::PERCENT_FULL;
        end else if (row_ext == whole_reg) begin
            intensity = pct_prod[PCT_PROD_W-1:sbb_pkg::FRAC_W];
        end else begin
            intensity = '0;
        end
        load_out = busy_reg && (!tvalid_reg || m_tready);
    end

    // Row stepping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            row_reg  <= '0;
        end else if (load_out) begin
            row_reg <= row_reg + 1'b1;
            if (row_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Captured update.
    always_ff @(posedge aclk) begin
        if (start) begin
            band_reg  <= req.band;
            whole_reg <= req.level[sbb_pkg::LEVEL_W-1:sbb_pkg::FRAC_W];
            frac_reg  <= req.level[sbb_pkg::FRAC_W-1:0];
        end
    end

    // Output register: a transfer leaves when the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (load_out) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            tdata_reg <= {{PAD_W{1'b0}}, intensity, row_ext, band_reg};
            tlast_reg <= row_last;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== tb/sv/spectrum_band_bargraph_top_tb.sv =====
// Self-checking testbench for the spectrum bar graph: directed table, random frames, predictor.
`timescale 1ns / 1ps

module spectrum_band_bargraph_top_tb;

    // Widths and limits taken from the shared package.
    localparam int MAG_W       = sbb_pkg::MAG_W;
    localparam int BAND_W      = sbb_pkg::BAND_W;
    localparam int ROW_W       = sbb_pkg::ROW_W;
    localparam int INTEN_W     = sbb_pkg::INTEN_W;
    localparam int GAIN_W      = sbb_pkg::GAIN_W;
    localparam int CAP_W       = sbb_pkg::CAP_W;
    localparam int FRAC_W      = sbb_pkg::FRAC_W;
    localparam int LEVEL_W     = sbb_pkg::LEVEL_W;
    localparam int ROOT_W      = sbb_pkg::ROOT_W;
    localparam int S_DATA_W    = sbb_pkg::S_DATA_W;
    localparam int M_DATA_W    = sbb_pkg::M_DATA_W;
    localparam int CFG_IDX_W   = sbb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = sbb_pkg::CFG_DATA_W;
    localparam int OCTAVE_SPAN = sbb_pkg::OCTAVE_SPAN;

    localparam int NUM_BANDS   = sbb_pkg::NUM_BANDS_DEF;
    localparam int MAX_BIN     = sbb_pkg::MAX_BIN_DEF;
    localparam int NUM_ROWS    = sbb_pkg::NUM_ROWS_DEF;
    localparam int PAD_LSB     = BAND_W + ROW_W + INTEN_W;
    localparam int BIN_SAT     = 127;
    localparam int IDLE_SETTLE = 64;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 20;
    localparam int DIRECTED_LEN = 21;
    localparam int SAVED_MAX   = 160;

    // One row result of a bar redraw.
    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [ROW_W-1:0]   row;
        logic [INTEN_W-1:0] intensity;
        logic               last;
    } bar_row_t;

    // How the expected rows of a directed bin are obtained.
    typedef enum logic [1:0] {
        ROWS_PREDICTED,
        ROWS_FULL,
        ROWS_DARK,
        ROWS_NONE
    } bar_expect_e;

    typedef struct packed {
        logic              frame_start;
        logic [MAG_W-1:0]  magnitude;
        bar_expect_e       kind;
        logic [BAND_W-1:0] band;
    } directed_bin_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: registers, band grouping and the stored bar levels.
    logic [GAIN_W-1:0]  model_gain;
    logic [CAP_W-1:0]   model_cap;
    logic [MAG_W-1:0]   model_peak;
    int unsigned        model_bin_count;
    int unsigned        model_band_index;
    logic [LEVEL_W-1:0] model_prev_level [NUM_BANDS];
    int unsigned        band_edge [NUM_BANDS];

    bar_row_t    bar_rows_due [$];
    bar_row_t    seen_want;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          phase_items = 0;
    bit          hold_output = 1'b0;
    bit          no_idling = 1'b0;
    bit          sender_gappy = 1'b1;
    logic [MAG_W-1:0] saved_frame [SAVED_MAX];
    int          saved_len = 0;

    // Directed bins, starting without a frame marker; bands 0 to 7 each hold one bin.
    directed_bin_t directed_bins [DIRECTED_LEN] = '{
        '{1'b0, 16'hFFFF, ROWS_FULL,      5'd0},
        '{1'b0, 16'h0000, ROWS_NONE,      5'd1},
        '{1'b1, 16'h1234, ROWS_NONE,      5'd0},
        '{1'b0, 16'hFFFF, ROWS_NONE,      5'd0},
        '{1'b0, 16'h0001, ROWS_PREDICTED, 5'd1},
        '{1'b0, 16'h8000, ROWS_FULL,      5'd2},
        '{1'b0, 16'h0400, ROWS_PREDICTED, 5'd3},
        '{1'b0, 16'hAAAA, ROWS_PREDICTED, 5'd4},
        '{1'b0, 16'h5555, ROWS_PREDICTED, 5'd5},
        '{1'b0, 16'h0000, ROWS_NONE,      5'd6},
        '{1'b0, 16'h00FF, ROWS_PREDICTED, 5'd7},
        '{1'b1, 16'hFFFF, ROWS_NONE,      5'd0},
        '{1'b0, 16'h0000, ROWS_DARK,      5'd0},
        '{1'b0, 16'h0001, ROWS_NONE,      5'd1},
        '{1'b0, 16'h0000, ROWS_DARK,      5'd2},
        '{1'b0, 16'hFFFE, ROWS_PREDICTED, 5'd3},
        '{1'b0, 16'h0010, ROWS_PREDICTED, 5'd4},
        '{1'b0, 16'h7FFF, ROWS_PREDICTED, 5'd5},
        '{1'b0, 16'hFFFF, ROWS_FULL,      5'd6},
        '{1'b0, 16'h0100, ROWS_PREDICTED, 5'd7},
        '{1'b1, 16'h0000, ROWS_NONE,      5'd0}
    };

    spectrum_band_bargraph_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with an 8 ns period.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Integer square root, one result bit per pass.
    function automatic logic [ROOT_W-1:0] square_root(input logic [2*ROOT_W-1:0] value);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int i = ROOT_W - 1; i >= 0; i--) begin
            trial = root | (ROOT_W'(1) << i);
            if (64'(trial) * 64'(trial) <= 64'(value)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Magnitude spread over the whole range, with the extremes appearing often.
    function automatic logic [MAG_W-1:0] random_magnitude();
        logic [MAG_W-1:0] raw;
        raw = MAG_W'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return raw >> $urandom_range(0, 15);
            end
        endcase
    endfunction

    // Work out the rows that one accepted bin causes and queue them; returns how many.
    task automatic predict_bar_rows(input logic frame_start, input logic [MAG_W-1:0] magnitude,
                                    output int n_rows);
        int unsigned bin_pos;
        int unsigned band;
        int unsigned product;
        int unsigned level_wide;
        int unsigned whole;
        int unsigned frac;
        logic [LEVEL_W-1:0] level;
        bar_row_t r;
        n_rows = 0;
        if (frame_start) begin
            model_peak = '0;
            model_bin_count = 0;
            model_band_index = 0;
            return;
        end
        bin_pos = model_bin_count;
        if (model_bin_count < BIN_SAT) begin
            model_bin_count++;
        end
        band = model_band_index;
        if (band >= NUM_BANDS || bin_pos >= band_edge[band]) begin
            return;
        end
        if (magnitude > model_peak) begin
            model_peak = magnitude;
        end
        if (bin_pos + 1 != band_edge[band]) begin
            return;
        end

        // Band closed: gain times root, saturated to the cap in whole rows.
        product = model_gain * square_root({model_peak, 16'h0000});
        level_wide = product >> FRAC_W;
        if (level_wide > (int'(model_cap) << FRAC_W)) begin
            level_wide = int'(model_cap) << FRAC_W;
        end
        level = LEVEL_W'(level_wide);
        model_peak = '0;
        if (model_band_index + 1 < NUM_BANDS) begin
            model_band_index++;
        end
        if (level == model_prev_level[band]) begin
            return;
        end
        model_prev_level[band] = level;
        whole = level >> FRAC_W;
        frac = level[FRAC_W-1:0];
        for (int j = 0; j < NUM_ROWS; j++) begin
            r.band = BAND_W'(band);
            r.row = ROW_W'(j);
            if (j < whole) begin
                r.intensity = sbb_pkg::PERCENT_FULL;
            end else if (j == whole) begin
                r.intensity = INTEN_W'((frac * 100) >> FRAC_W);
            end else begin
                r.intensity = '0;
            end
            r.last = (j == NUM_ROWS - 1);
            bar_rows_due.push_back(r);
            n_rows++;
        end
    endtask

    // Offer one bin, with an occasional gap first, and predict on the transfer.
    task automatic send_bin(input logic frame_start, input logic [MAG_W-1:0] magnitude,
                            output int n_rows);
        @(negedge aclk);
        if (!no_idling && sender_gappy && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = magnitude;
        s_tuser = frame_start;
        do @(posedge aclk); while (!s_tready);
        predict_bar_rows(frame_start, magnitude, n_rows);
    endtask

    // Let every expected row arrive, then give a bin with no rows time to finish.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (bar_rows_due.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        if (index == sbb_pkg::REG_LEVEL_GAIN) begin
            model_gain = data[GAIN_W-1:0];
        end else begin
            model_cap = data[CAP_W-1:0];
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One frame: a marker bin, then bins that are either replayed or fresh.
    task automatic run_frame(input int n_bins, input bit replay);
        logic [MAG_W-1:0] magnitude;
        int n_rows;
        sender_gappy = $urandom_range(0, 1);
        send_bin(1'b1, random_magnitude(), n_rows);
        phase_items++;
        for (int i = 0; i < n_bins; i++) begin
            if (replay && i < saved_len) begin
                magnitude = saved_frame[i];
            end else begin
                magnitude = random_magnitude();
            end
            if (i < SAVED_MAX) begin
                saved_frame[i] = magnitude;
            end
            send_bin(1'b0, magnitude, n_rows);
            phase_items++;
        end
        saved_len = (n_bins < SAVED_MAX) ? n_bins : SAVED_MAX;
    endtask

    // Output side: random stall bursts, one long hold on request, none at the end.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_output = 1'b0;
            end else if (no_idling) begin
                m_tready = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge aclk);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Compare each output transfer with the oldest expected row.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (bar_rows_due.size() == 0) begin
                report_mismatch("unexpected row, tdata", m_tdata, 0);
            end else begin
                seen_want = bar_rows_due.pop_front();
                if (m_tdata[BAND_W-1:0] != seen_want.band) begin
                    report_mismatch("band", m_tdata[BAND_W-1:0], seen_want.band);
                end
                if (m_tdata[BAND_W +: ROW_W] != seen_want.row) begin
                    report_mismatch("row", m_tdata[BAND_W +: ROW_W], seen_want.row);
                end
                if (m_tdata[BAND_W+ROW_W +: INTEN_W] != seen_want.intensity) begin
                    report_mismatch("intensity", m_tdata[BAND_W+ROW_W +: INTEN_W],
                                    seen_want.intensity);
                end
                if ((m_tdata >> PAD_LSB) != 0) begin
                    report_mismatch("padding", m_tdata >> PAD_LSB, 0);
                end
                if (m_tlast != seen_want.last) begin
                    report_mismatch("tlast", m_tlast, seen_want.last);
                end
            end
        end
    end

    // Guard against a hang.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Main stimulus.
    initial begin
        logic [127:0] power;
        int unsigned fit_end;
        int unsigned prev_end;
        int n_rows;
        logic [GAIN_W-1:0] phase_gain;
        logic [CAP_W-1:0] phase_cap;
        bar_row_t r;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = sbb_pkg::REG_LEVEL_GAIN;
        cfg_data = '0;

        // Band edges: largest e with e^(bands-1) <= 2^(span*x), kept increasing and capped.
        prev_end = 0;
        for (int x = 0; x < NUM_BANDS; x++) begin
            fit_end = 1;
            for (int e = 1; e <= 32; e++) begin
                power = 128'd1;
                repeat (NUM_BANDS - 1) power = power * 128'(e);
                if (power <= (128'd1 << (OCTAVE_SPAN * x))) begin
                    fit_end = e;
                end
            end
            if (fit_end <= prev_end) begin
                fit_end = prev_end + 1;
            end
            if (fit_end > MAX_BIN) begin
                fit_end = MAX_BIN;
            end
            band_edge[x] = fit_end;
            if (fit_end > prev_end) begin
                prev_end = fit_end;
            end
        end

        model_gain = sbb_pkg::LEVEL_GAIN_RST;
        model_cap = sbb_pkg::LEVEL_CAP_RST;
        model_peak = '0;
        model_bin_count = 0;
        model_band_index = 0;
        for (int b = 0; b < NUM_BANDS; b++) begin
            model_prev_level[b] = '0;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under the reset register values; fixed rows replace the prediction.
        for (int k = 0; k < DIRECTED_LEN; k++) begin
            send_bin(directed_bins[k].frame_start, directed_bins[k].magnitude, n_rows);
            if (directed_bins[k].kind != ROWS_PREDICTED) begin
                repeat (n_rows) void'(bar_rows_due.pop_back());
                if (directed_bins[k].kind != ROWS_NONE) begin
                    for (int j = 0; j < NUM_ROWS; j++) begin
                        r.band = directed_bins[k].band;
                        r.row = ROW_W'(j);
                        r.intensity = (directed_bins[k].kind == ROWS_FULL)
                                    ? sbb_pkg::PERCENT_FULL : '0;
                        r.last = (j == NUM_ROWS - 1);
                        bar_rows_due.push_back(r);
                    end
                end
            end
        end

        // Random frames, one register setting per phase.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    phase_gain = '1;
                    phase_cap = 3'd7;
                end
                1: begin
                    phase_gain = '0;
                    phase_cap = 3'd6;
                end
                2: begin
                    phase_gain = GAIN_W'($urandom);
                    phase_cap = 3'd0;
                end
                3: begin
                    phase_gain = GAIN_W'($urandom);
                    phase_cap = CAP_W'($urandom_range(0, 7));
                end
                4: begin
                    phase_gain = 8'd1;
                    phase_cap = 3'd7;
                end
                default: begin
                    phase_gain = sbb_pkg::LEVEL_GAIN_RST;
                    phase_cap = sbb_pkg::LEVEL_CAP_RST;
                    no_idling = 1'b1;
                end
            endcase
            write_reg(sbb_pkg::REG_LEVEL_GAIN, CFG_DATA_W'(phase_gain));
            write_reg(sbb_pkg::REG_LEVEL_CAP, CFG_DATA_W'(phase_cap));
            if (p == 0) begin
                hold_output = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Frame cut short: the open band is dropped.
                    run_frame($urandom_range(3, band_edge[NUM_BANDS-1] - 1), 1'b0);
                end else begin
                    run_frame($urandom_range(band_edge[NUM_BANDS-1], band_edge[NUM_BANDS-1] + 6),
                              ($urandom_range(0, 3) == 0));
                end
            end
        end

        // Drain and decide.
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (bar_rows_due.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sbb_pkg.sv
hdl/sbb_isqrt.sv
hdl/sbb_scale.sv
hdl/sbb_rows.sv
hdl/spectrum_band_bargraph_top.sv
tb/sv/spectrum_band_bargraph_top_tb.sv
